// ----- hw/rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and defaults for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_WORDS_DEF = 1024;
  localparam int MIN_WORDS_DEF = 8;
  localparam int MAX_BLOCK_DEF = 63;

  // request codes
  localparam logic [2:0] FUNC_ALLOC = 3'd0;
  localparam logic [2:0] FUNC_DATA  = 3'd1;
  localparam logic [2:0] FUNC_FREE  = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_USAGE = 3'd4;

  // error codes carried in result_value
  localparam logic [31:0] ERR_NO_ROOM  = 32'hFFFF_FFFF;
  localparam logic [31:0] ERR_TOO_LONG = 32'hFFFF_FFFE;
  localparam logic [31:0] ERR_BAD_FREE = 32'hFFFF_FFFD;
  localparam logic [31:0] ERR_BAD_READ = 32'hFFFF_FFFC;
  localparam logic [31:0] ERR_BAD_FUNC = 32'hFFFF_FFFB;
  localparam logic [31:0] ERR_NO_FILL  = 32'hFFFF_FFFA;

  typedef enum logic [2:0] {
    KIND_ADDR  = 3'd0,
    KIND_WORD  = 3'd1,
    KIND_USAGE = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DW,
    S_AL_RD,
    S_AL_CHK,
    S_AL_GROW,
    S_AL_WR,
    S_BK_HDR_RD,
    S_BK_HDR_CHK,
    S_BK_WD_RD,
    S_BK_WD_CHK,
    S_FR_CLR,
    S_FR_FILL_RD,
    S_FR_FILL_CHK,
    S_FR_Q_RD,
    S_FR_Q_CHK,
    S_RD_RD,
    S_RD_OUT,
    S_EMIT
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [10:0] current_size;
    logic        last;
  } res_t;

endpackage

// ----- hw/rtl/first_fit_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit block allocator over a word store with a length header per block.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_*: one item per request (alloc, data word, free, read,
//    usage). An item is taken when in_valid is high and in_stall is low.
//  - Result channel out_*: one item per result; out_last marks the final one
//    of a request. Successful data word and free requests give no result.
//  - One request is worked at a time; in_stall stays high until it is done.
//  - Store reads are registered, so every word inspected takes a read state
//    and a check state. Alloc: scans up to MAX_WORDS words, grows the size
//    as needed, then writes the header and len zero words. Free: checks the
//    block, clears its header and words, then scans the upper three quarters
//    of the size for a used word. Read: checks the block, then streams each
//    word. Data word: one write. Usage and entry-rejected requests: one result.
//  - Reset: a clearing pass over all MAX_WORDS words wipes every valid bit; the
//    block holds in_stall high during it.
//  - Results go through a single output register; when the receiver stalls,
//    that register holds and the sequencer waits before producing the next.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
  parameter int MAX_WORDS = ffba_pkg::MAX_WORDS_DEF,
  parameter int MIN_WORDS = ffba_pkg::MIN_WORDS_DEF,
  parameter int MAX_BLOCK = ffba_pkg::MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [5:0]         in_block_length,
  input  logic [9:0]         in_block_address,
  input  logic signed [31:0] in_word_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [31:0] out_result_value,
  output logic [10:0]        out_current_size,
  output logic               out_last
);
  import ffba_pkg::*;

  logic  ready;
  logic  push;
  logic  slot_free;
  res_t  res;
  logic  out_valid_r;
  res_t  out_r;

  // output slot can take a new result when empty or being drained
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !ready;

  ffba_core #(
    .MAX_WORDS (MAX_WORDS),
    .MIN_WORDS (MIN_WORDS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_len    (in_block_length),
    .in_addr   (in_block_address),
    .in_word   (in_word_value),
    .ready     (ready),
    .slot_free (slot_free),
    .push      (push),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads only on a push, so it holds while stalled
  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_result_value = out_r.value;
  assign out_current_size = out_r.current_size;
  assign out_last         = out_r.last;

endmodule

// ----- hw/rtl/ffba_core.sv -----
// ----------------------------------------------------------------------------
// ffba_core
// Word store with valid bits and the sequencer that scans, fills and frees it.
// ----------------------------------------------------------------------------
module ffba_core #(
  parameter int MAX_WORDS = ffba_pkg::MAX_WORDS_DEF,
  parameter int MIN_WORDS = ffba_pkg::MIN_WORDS_DEF,
  parameter int MAX_BLOCK = ffba_pkg::MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_func,
  input  logic [5:0]         in_len,
  input  logic [9:0]         in_addr,
  input  logic [31:0]        in_word,
  output logic               ready,
  input  logic               slot_free,
  output logic               push,
  output ffba_pkg::res_t     res
);
  import ffba_pkg::*;

  localparam int AW  = $clog2(MAX_WORDS);
  localparam int SW  = $clog2(MAX_WORDS + 1);
  localparam int PW0 = $clog2(MAX_WORDS + 128);
  localparam int PW  = (PW0 > 11) ? PW0 : 11;

  // bit 32 is the valid flag
  logic [32:0]   mem [MAX_WORDS];
  logic [32:0]   rd_data_r;
  logic          mem_we;
  logic [PW-1:0] mem_wptr;
  logic [32:0]   mem_wdata;

  state_t        state_r, state_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] fptr_r, fptr_nxt;
  logic [5:0]    len_r, len_nxt;
  logic [5:0]    frem_r, frem_nxt;
  logic [6:0]    run_r, run_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [SW-1:0] tsize_r, tsize_nxt;
  logic [10:0]   used_r, used_nxt;
  kind_t         rkind_r, rkind_nxt;
  logic [31:0]   rval_r, rval_nxt;

  logic          v;
  logic [31:0]   dword;
  logic          in_fire, ptr_last, fit, hdr_bad, hdr_zero, wd_done, len_big;
  logic          in_addr_bad, fill_bad, grow_fit, size_last, halve_ok, clr_done;
  logic          al_done;
  logic [6:0]    run_inc;
  logic [PW-1:0] blk_end;
  logic [SW:0]   tsize_dbl;
  logic [SW-1:0] tsize_grow;
  logic [6:0]    len_p1;

  assign v           = rd_data_r[32];
  assign dword       = rd_data_r[31:0];
  assign in_fire     = in_valid && (state_r == S_IDLE);
  assign ready       = (state_r == S_IDLE);
  assign ptr_last    = (ptr_r == PW'(MAX_WORDS - 1));
  assign run_inc     = run_r + 7'd1;
  assign len_p1      = {1'b0, len_r} + 7'd1;
  assign fit         = !v && (run_inc == len_p1);
  assign blk_end     = addr_r + PW'(len_r);
  assign hdr_zero    = (dword[5:0] == 6'd0);
  assign hdr_bad     = !v || (dword > 32'(MAX_BLOCK))
                       || ((addr_r + PW'(dword[5:0])) >= PW'(size_r));
  assign wd_done     = (ptr_r == blk_end);
  assign clr_done    = wd_done;
  // end of the header-and-zero write sweep of an alloc
  assign al_done     = (ptr_r == (pos_r + PW'(len_r)));
  assign len_big     = ({1'b0, in_len} > 7'(MAX_BLOCK));
  assign in_addr_bad = (PW'(in_addr) >= PW'(size_r));
  assign fill_bad    = (frem_r == 6'd0) || (fptr_r >= PW'(MAX_WORDS));
  assign grow_fit    = ((pos_r + PW'(len_r)) < PW'(tsize_r));
  assign tsize_dbl   = {tsize_r, 1'b0};
  assign tsize_grow  = (tsize_dbl > (SW+1)'(MAX_WORDS)) ? SW'(MAX_WORDS)
                                                        : tsize_dbl[SW-1:0];
  assign size_last   = (ptr_r == (PW'(size_r) - PW'(1)));
  assign halve_ok    = ((size_r >> 1) >= SW'(MIN_WORDS));

  // store: one write port, one registered read port at ptr_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wptr[AW-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      size_r  <= SW'(MIN_WORDS);
      used_r  <= '0;
      fptr_r  <= '0;
      frem_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      size_r  <= size_nxt;
      used_r  <= used_nxt;
      fptr_r  <= fptr_nxt;
      frem_r  <= frem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    pos_r   <= pos_nxt;
    len_r   <= len_nxt;
    run_r   <= run_nxt;
    func_r  <= func_nxt;
    word_r  <= word_nxt;
    tsize_r <= tsize_nxt;
    rkind_r <= rkind_nxt;
    rval_r  <= rval_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FUNC_ALLOC: state_nxt = len_big ? S_EMIT : S_AL_RD;
            FUNC_DATA:  state_nxt = fill_bad ? S_EMIT : S_DW;
            FUNC_FREE,
            FUNC_READ:  state_nxt = in_addr_bad ? S_EMIT : S_BK_HDR_RD;
            default:    state_nxt = S_EMIT;
          endcase
        end
      end
      S_DW:        state_nxt = S_IDLE;
      S_AL_RD:     state_nxt = S_AL_CHK;
      S_AL_CHK: begin
        if (fit)           state_nxt = S_AL_GROW;
        else if (ptr_last) state_nxt = S_EMIT;
        else               state_nxt = S_AL_RD;
      end
      S_AL_GROW: begin
        if (grow_fit) state_nxt = S_AL_WR;
      end
      S_AL_WR: begin
        if (al_done) state_nxt = S_EMIT;
      end
      S_BK_HDR_RD: state_nxt = S_BK_HDR_CHK;
      S_BK_HDR_CHK: begin
        if (hdr_bad)                 state_nxt = S_EMIT;
        else if (!hdr_zero)          state_nxt = S_BK_WD_RD;
        else if (func_r == FUNC_FREE) state_nxt = S_FR_CLR;
        else                         state_nxt = S_EMIT;
      end
      S_BK_WD_RD: state_nxt = S_BK_WD_CHK;
      S_BK_WD_CHK: begin
        if (!v)                       state_nxt = S_EMIT;
        else if (!wd_done)            state_nxt = S_BK_WD_RD;
        else if (func_r == FUNC_FREE) state_nxt = S_FR_CLR;
        else                          state_nxt = S_RD_RD;
      end
      S_FR_CLR: begin
        if (clr_done) begin
          if (frem_r != 6'd0 && fptr_r < PW'(MAX_WORDS)) state_nxt = S_FR_FILL_RD;
          else                                           state_nxt = S_FR_Q_RD;
        end
      end
      S_FR_FILL_RD:  state_nxt = S_FR_FILL_CHK;
      S_FR_FILL_CHK: state_nxt = S_FR_Q_RD;
      S_FR_Q_RD:     state_nxt = S_FR_Q_CHK;
      S_FR_Q_CHK: begin
        if (v || size_last) state_nxt = S_IDLE;
        else                state_nxt = S_FR_Q_RD;
      end
      S_RD_RD: state_nxt = S_RD_OUT;
      S_RD_OUT: begin
        if (slot_free) state_nxt = wd_done ? S_IDLE : S_RD_RD;
      end
      S_EMIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    ptr_nxt   = ptr_r;
    addr_nxt  = addr_r;
    pos_nxt   = pos_r;
    fptr_nxt  = fptr_r;
    len_nxt   = len_r;
    frem_nxt  = frem_r;
    run_nxt   = run_r;
    func_nxt  = func_r;
    word_nxt  = word_r;
    size_nxt  = size_r;
    tsize_nxt = tsize_r;
    used_nxt  = used_r;
    rkind_nxt = rkind_r;
    rval_nxt  = rval_r;
    mem_we    = 1'b0;
    mem_wptr  = ptr_r;
    mem_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_last ? '0 : ptr_r + PW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          len_nxt   = in_len;
          addr_nxt  = PW'(in_addr);
          word_nxt  = in_word;
          func_nxt  = in_func;
          rkind_nxt = KIND_ERROR;
          case (in_func)
            FUNC_ALLOC: begin
              rval_nxt = ERR_TOO_LONG;
              ptr_nxt  = '0;
              run_nxt  = '0;
            end
            FUNC_DATA: rval_nxt = ERR_NO_FILL;
            FUNC_FREE: begin
              rval_nxt = ERR_BAD_FREE;
              ptr_nxt  = PW'(in_addr);
            end
            FUNC_READ: begin
              rval_nxt = ERR_BAD_READ;
              ptr_nxt  = PW'(in_addr);
            end
            FUNC_USAGE: begin
              rkind_nxt = KIND_USAGE;
              rval_nxt  = 32'(used_r);
            end
            default: rval_nxt = ERR_BAD_FUNC;
          endcase
        end
      end
      S_DW: begin
        mem_we    = 1'b1;
        mem_wptr  = fptr_r;
        mem_wdata = {1'b1, word_r};
        fptr_nxt  = fptr_r + PW'(1);
        frem_nxt  = frem_r - 6'd1;
      end
      S_AL_CHK: begin
        if (fit) begin
          pos_nxt   = ptr_r - PW'(len_r);
          tsize_nxt = size_r;
        end else begin
          run_nxt  = v ? 7'd0 : run_inc;
          ptr_nxt  = ptr_r + PW'(1);
          rval_nxt = ERR_NO_ROOM;
        end
      end
      S_AL_GROW: begin
        if (grow_fit) begin
          size_nxt = tsize_r;
          ptr_nxt  = pos_r;
        end else begin
          tsize_nxt = tsize_grow;
        end
      end
      S_AL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (ptr_r == pos_r) ? {1'b1, 26'd0, len_r} : {1'b1, 32'd0};
        ptr_nxt   = ptr_r + PW'(1);
        if (al_done) begin
          used_nxt  = used_r + 11'(len_r) + 11'd1;
          fptr_nxt  = pos_r + PW'(1);
          frem_nxt  = len_r;
          rkind_nxt = KIND_ADDR;
          rval_nxt  = 32'(pos_r);
        end
      end
      S_BK_HDR_CHK: begin
        len_nxt = dword[5:0];
        if (!hdr_bad) begin
          if (!hdr_zero) begin
            ptr_nxt = addr_r + PW'(1);
          end else if (func_r == FUNC_READ) begin
            rkind_nxt = KIND_EMPTY;
            rval_nxt  = 32'd0;
          end
        end
      end
      S_BK_WD_CHK: begin
        if (v) begin
          if (!wd_done)                 ptr_nxt = ptr_r + PW'(1);
          else if (func_r == FUNC_FREE) ptr_nxt = addr_r;
          else                          ptr_nxt = addr_r + PW'(1);
        end
      end
      S_FR_CLR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + PW'(1);
        if (clr_done) begin
          used_nxt = (used_r > 11'(len_p1)) ? used_r - 11'(len_p1) : 11'd0;
          if (frem_r != 6'd0 && fptr_r < PW'(MAX_WORDS)) begin
            ptr_nxt = fptr_r;
          end else begin
            if (frem_r != 6'd0) frem_nxt = 6'd0;
            ptr_nxt = PW'(size_r >> 2);
          end
        end
      end
      S_FR_FILL_CHK: begin
        if (!v) frem_nxt = 6'd0;
        ptr_nxt = PW'(size_r >> 2);
      end
      S_FR_Q_CHK: begin
        ptr_nxt = ptr_r + PW'(1);
        if (!v && size_last && halve_ok) size_nxt = size_r >> 1;
      end
      S_RD_OUT: begin
        if (slot_free && !wd_done) ptr_nxt = ptr_r + PW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    push = slot_free && (state_r == S_EMIT || state_r == S_RD_OUT);
    res.current_size = 11'(size_r);
    if (state_r == S_RD_OUT) begin
      res.kind  = KIND_WORD;
      res.value = dword;
      res.last  = wd_done;
    end else begin
      res.kind  = rkind_r;
      res.value = rval_r;
      res.last  = 1'b1;
    end
  end

endmodule

// ----- hw/rtl/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator, bound to the top.
// ----------------------------------------------------------------------------
module ffba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [31:0] out_result_value,
  input logic [10:0] out_current_size,
  input logic        out_last
);
  import ffba_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_kind) && $stable(out_last) && $stable(out_current_size))
    else $error("stalled result changed");

  // one request at a time: busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("took an item while busy");

  // only block words can be followed by more results of the same request
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_WORD) |-> out_last)
    else $error("non-word result without last");

  // clearing pass and empty output after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("not held after reset");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_result_value (out_result_value),
  .out_current_size (out_current_size),
  .out_last         (out_last)
);

// ----- tb/ffba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_tb_checker
// Watches both channels of the allocator, predicts each result item from its
// own copy of the store and compares field by field in arrival order.
// ----------------------------------------------------------------------------
module ffba_tb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [5:0]         in_block_length,
  input  logic [9:0]         in_block_address,
  input  logic signed [31:0] in_word_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_kind,
  input  logic signed [31:0] out_result_value,
  input  logic [10:0]        out_current_size,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);
  import ffba_pkg::*;

  localparam int NW = MAX_WORDS_DEF;

  logic [31:0] mem_word [NW];
  logic        mem_busy [NW];
  int          size_q;
  int          used_q;
  int          fill_ptr;
  int          fill_left;
  res_t        expected_q [$];

  assign pending = expected_q.size();

  function automatic bit span_free(int pos, int len, int sz);
    if (pos + len >= sz) return 0;
    for (int i = 0; i <= len; i++) if (mem_busy[pos + i]) return 0;
    return 1;
  endfunction

  function automatic bit header_ok(int a);
    int len;
    if (a >= size_q || !mem_busy[a]) return 0;
    len = int'(mem_word[a]);
    if (mem_word[a] > MAX_BLOCK_DEF || a + len >= size_q) return 0;
    for (int i = 1; i <= len; i++) if (!mem_busy[a + i]) return 0;
    return 1;
  endfunction

  task automatic push(kind_t k, logic [31:0] v, bit l);
    res_t r;
    r.kind = k; r.value = v; r.current_size = size_q[10:0]; r.last = l;
    expected_q.push_back(r);
  endtask

  task automatic predict_item(logic [2:0] f, int len, int addr, logic [31:0] w);
    int sz, pos, a;
    bit found, clear;
    case (f)
      FUNC_ALLOC: begin
        sz = size_q;
        found = 0;
        forever begin
          for (int p = 0; p < sz && !found; p++)
            if (span_free(p, len, sz)) begin
              found = 1; pos = p;
            end
          if (found || sz >= NW) break;
          sz = (sz * 2 > NW) ? NW : sz * 2;
        end
        if (!found) push(KIND_ERROR, ERR_NO_ROOM, 1'b1);
        else begin
          size_q = sz;
          mem_word[pos] = 32'(len); mem_busy[pos] = 1;
          for (int i = 1; i <= len; i++) begin
            mem_word[pos + i] = '0; mem_busy[pos + i] = 1;
          end
          used_q = (used_q + len + 1) & 11'h7FF;
          fill_ptr = pos + 1; fill_left = len;
          push(KIND_ADDR, 32'(pos), 1'b1);
        end
      end
      FUNC_DATA: begin
        if (fill_left == 0 || fill_ptr >= NW) push(KIND_ERROR, ERR_NO_FILL, 1'b1);
        else begin
          mem_word[fill_ptr] = w; fill_ptr++; fill_left--;
        end
      end
      FUNC_FREE: begin
        if (!header_ok(addr)) push(KIND_ERROR, ERR_BAD_FREE, 1'b1);
        else begin
          a = int'(mem_word[addr]);
          for (int i = 0; i <= a; i++) mem_busy[addr + i] = 0;
          used_q = (used_q > a + 1) ? used_q - (a + 1) : 0;
          if (fill_left != 0 && (fill_ptr >= NW || !mem_busy[fill_ptr])) fill_left = 0;
          clear = 1;
          for (int i = size_q / 4; i < size_q; i++) if (mem_busy[i]) clear = 0;
          if (clear && size_q / 2 >= MIN_WORDS_DEF) size_q = size_q / 2;
        end
      end
      FUNC_READ: begin
        if (!header_ok(addr)) push(KIND_ERROR, ERR_BAD_READ, 1'b1);
        else begin
          a = int'(mem_word[addr]);
          if (a == 0) push(KIND_EMPTY, 32'd0, 1'b1);
          for (int i = 0; i < a; i++) push(KIND_WORD, mem_word[addr + 1 + i], i + 1 == a);
        end
      end
      FUNC_USAGE: push(KIND_USAGE, 32'(used_q), 1'b1);
      default: push(KIND_ERROR, ERR_BAD_FUNC, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    res_t got, exp_r;
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) begin
        mem_busy[i] = 0; mem_word[i] = 0;
      end
      size_q = MIN_WORDS_DEF; used_q = 0; fill_ptr = 0; fill_left = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      // results first: an item's own results cannot appear in its accept cycle
      if (out_valid && !out_stall) begin
        got.kind = kind_t'(out_kind); got.value = out_result_value;
        got.current_size = out_current_size; got.last = out_last;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: exp %p got %p", exp_r, got);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_item(in_func, int'(in_block_length), int'(in_block_address),
                     in_word_value);
    end
  end

endmodule

// ----- tb/first_fit_block_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top_tb
// Drives alloc/fill/read/free/usage traffic into the allocator under several
// idle and stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top_tb;
  import ffba_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_func;
  logic [5:0]         in_block_length;
  logic [9:0]         in_block_address;
  logic signed [31:0] in_word_value;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_kind;
  logic signed [31:0] out_result_value;
  logic [10:0]        out_current_size;
  logic               out_last;
  int                 fail_count;
  int                 pending;

  int  send_idle_pct;        // chance in 100 of a gap before an item
  int  recv_stall_pct;       // chance in 100 of stalling the result side
  bit  hold_req;             // asks the receiver for one long hold-off
  bit  hold_taken = 1'b0;    // hold-off already started
  int  hold_cycles = 0;      // long receiver hold-off, counted down below
  int  cycle_count = 0;
  int  sent;
  int  live_addr [$];        // candidate header addresses, drawn at random

  first_fit_block_allocator_top dut (.*);
  ffba_tb_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog; the reset clearing pass and slow scans are well inside this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, or forced stall during a hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_cycles <= 2999;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one item, held until accepted; optional gap before it
  task automatic send(logic [2:0] f, logic [5:0] len, logic [9:0] addr, logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_func <= f; in_block_length <= len;
    in_block_address <= addr; in_word_value <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // alloc followed by a fill of n data words (may be partial)
  task automatic alloc_fill(int len, int n);
    send(FUNC_ALLOC, 6'(len), 10'($urandom), $urandom);
    for (int i = 0; i < n; i++) send(FUNC_DATA, 6'($urandom), 10'($urandom), $urandom);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8000) @(negedge clk);
  endtask

  task automatic random_item();
    int r, len, a;
    r = int'($urandom_range(99));
    len = ($urandom_range(9) == 0) ? int'($urandom_range(63)) : int'($urandom_range(7));
    a = (live_addr.size() != 0) ? live_addr[$urandom_range(live_addr.size() - 1)] : 0;
    if (r < 30) begin
      // mostly full fills, sometimes cut short
      alloc_fill(len, ($urandom_range(5) == 0) ? int'($urandom_range(len)) : len);
      live_addr.push_back(int'($urandom_range(40)));
    end else if (r < 45) begin
      send(FUNC_READ, 6'($urandom), (r & 1) ? 10'(a) : 10'($urandom_range(63)), $urandom);
    end else if (r < 60) begin
      send(FUNC_FREE, 6'($urandom), (r & 1) ? 10'(a) : 10'($urandom_range(63)), $urandom);
    end else if (r < 70) begin
      send(FUNC_USAGE, 6'($urandom), 10'($urandom), $urandom);
    end else if (r < 75) begin
      send(FUNC_DATA, 6'($urandom), 10'($urandom), $urandom);
    end else if (r < 78) begin
      send(3'($urandom_range(7, 5)), 6'($urandom), 10'($urandom), $urandom);
    end else begin
      send(3'($urandom_range(4)), 6'($urandom), 10'($urandom_range(1023)), $urandom);
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_func = FUNC_USAGE; in_block_length = 0;
    in_block_address = 0; in_word_value = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0;
    sent = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // directed: extremes, every func and each reachable error path
    send(FUNC_USAGE, 6'd0, 10'd0, 32'd0);
    send(FUNC_DATA, 6'd0, 10'd0, 32'h7FFF_FFFF);      // no fill pending
    alloc_fill(0, 0);                                 // empty block at 0
    send(FUNC_READ, 6'd0, 10'd0, 32'd0);              // empty-block result
    alloc_fill(3, 3);
    send(FUNC_DATA, 6'd0, 10'd0, 32'd0);
    alloc_fill(63, 2);                                // longest, grows the size
    alloc_fill(2, 1);                                 // takes over the fill
    send(FUNC_DATA, 6'h3F, 10'h3FF, 32'h8000_0000);
    send(FUNC_READ, 6'd0, 10'd1, 32'd0);
    send(FUNC_READ, 6'd0, 10'h3FF, 32'd0);            // bad read
    send(FUNC_FREE, 6'd0, 10'h3FF, 32'd0);            // bad free
    send(3'd5, 6'd0, 10'd0, 32'd0);
    send(3'd7, 6'h3F, 10'h3FF, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) alloc_fill(63, 0);   // runs out of room
    send(FUNC_USAGE, 6'd0, 10'd0, 32'd0);
    drain();
    // the looped long blocks sit on multiples of 8; the first long one at 5, the short ones at 0, 1 and 69
    for (int i = 0; i < 1024; i += 8) send(FUNC_FREE, 6'd0, 10'(i), 32'd0);
    send(FUNC_FREE, 6'd0, 10'd1, 32'd0);
    send(FUNC_FREE, 6'd0, 10'd5, 32'd0);
    send(FUNC_FREE, 6'd0, 10'd69, 32'd0);
    send(FUNC_USAGE, 6'd0, 10'd0, 32'd0);

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 58) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 58) : 0;
      if (ph == 2) hold_req = 1;                      // fill up and back-pressure
      for (int i = 0; i < 10; i++) random_item();
    end
    drain();

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
